// ===== src/fasq_pkg.sv =====
// ----------------------------------------------------------------------------
// Frame advance signal qualifier package
// Shared types and constants for the qualifier core, its buffer and channels.
// ----------------------------------------------------------------------------
package fasq_pkg;

   // Widths of the channel fields.
   localparam int EVENT_COUNT_W = 20;
   localparam int CSR_DATA_W    = 16;
   localparam int CSR_INDEX_W   = 2;

   // Register indexes on the configuration channel.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DEBOUNCE      = 2'd0,
      CSR_ADVANCE_PULSE = 2'd1,
      CSR_END_PULSE     = 2'd2
   } csr_index_type;

   // Values the configuration registers take after reset.
   localparam logic [CSR_DATA_W-1:0] DEBOUNCE_RESET      = 16'd1500;
   localparam logic [CSR_DATA_W-1:0] ADVANCE_PULSE_RESET = 16'd8000;
   localparam logic [CSR_DATA_W-1:0] END_PULSE_RESET     = 16'd16000;

   // Event codes reported with each result.
   typedef enum logic [1:0] {
      EVT_NONE  = 2'd0,
      EVT_FRAME = 2'd1,
      EVT_END   = 2'd2
   } event_code_type;

   // One result item as it travels through the output buffer.
   typedef struct packed {
      logic                     advance_out;
      logic                     end_out;
      logic                     led_on;
      event_code_type           event_code;
      logic [EVENT_COUNT_W-1:0] event_count;
   } rsp_payload_type;

endpackage

// ===== src/fasq_req_if.sv =====
// ----------------------------------------------------------------------------
// Qualifier request channel
// Carries one tick of sampled advance and end-of-film pin levels.
// ----------------------------------------------------------------------------
interface fasq_req_if;
   logic valid;
   logic ready;
   logic advance_level;
   logic end_level;

   modport source (output valid, output advance_level, output end_level, input ready);
   modport sink   (input valid, input advance_level, input end_level, output ready);
endinterface

// ===== src/fasq_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Qualifier result channel
// Carries the output levels and the event report for one tick.
// ----------------------------------------------------------------------------
interface fasq_rsp_if import fasq_pkg::*; ;
   logic                     valid;
   logic                     ready;
   logic                     advance_out;
   logic                     end_out;
   logic                     led_on;
   logic [1:0]               event_code;
   logic [EVENT_COUNT_W-1:0] event_count;

   modport source (output valid, output advance_out, output end_out, output led_on,
                   output event_code, output event_count, input ready);
   modport sink   (input valid, input advance_out, input end_out, input led_on,
                   input event_code, input event_count, output ready);
endinterface

// ===== src/fasq_csr_if.sv =====
// ----------------------------------------------------------------------------
// Qualifier configuration channel
// Carries register writes: a register index and the data written.
// ----------------------------------------------------------------------------
interface fasq_csr_if import fasq_pkg::*; ;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/fasq_out_buffer.sv =====
// ----------------------------------------------------------------------------
// Qualifier output buffer
// Two-entry skid buffer that holds results while the result channel stalls.
// ----------------------------------------------------------------------------
module fasq_out_buffer import fasq_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  rsp_payload_type in_data,
   output logic            out_valid,
   input  logic            out_ready,
   output rsp_payload_type out_data
);

   logic            main_valid_ff;
   logic            skid_valid_ff;
   rsp_payload_type main_ff;
   rsp_payload_type skid_ff;
   logic            in_fire;
   logic            out_fire;

   // Room is left as long as the skid entry is empty.
   assign in_ready  = !skid_valid_ff;
   assign in_fire   = in_valid && in_ready;
   assign out_fire  = main_valid_ff && out_ready;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   // Valid flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_fire) begin
         if (skid_valid_ff) begin
            skid_valid_ff <= 1'b0;
         end else begin
            main_valid_ff <= in_fire;
         end
      end else if (in_fire) begin
         if (main_valid_ff) begin
            skid_valid_ff <= 1'b1;
         end else begin
            main_valid_ff <= 1'b1;
         end
      end
   end

   // Payload moves: the skid entry drains into the main entry first.
   always_ff @(posedge clock) begin
      if (out_fire) begin
         if (skid_valid_ff) begin
            main_ff <= skid_ff;
         end else begin
            main_ff <= in_data;
         end
      end else if (in_fire) begin
         if (main_valid_ff) begin
            skid_ff <= in_data;
         end else begin
            main_ff <= in_data;
         end
      end
   end

endmodule

// ===== src/frame_advance_signal_qualifier_core.sv =====
// ----------------------------------------------------------------------------
// Frame advance signal qualifier
// Debounces the frame-advance and end-of-film pins and stretches their pulses.
// ----------------------------------------------------------------------------
// Every request is one timer tick of sampled pin levels and yields exactly one
// result, which enters the output buffer on acceptance. The whole update
// of the debounce state, pulse timers and frame count is one pass of logic
// between the state registers, so a request can be accepted in every cycle.
// Results leave through a two-entry buffer; the request side stalls only when
// both entries are held by a stalled result channel. Configuration writes are
// always accepted and should be made while no request is in flight.
module frame_advance_signal_qualifier_core import fasq_pkg::*; #(
   parameter int COUNT_BITS = 20,
   parameter int TIMER_BITS = 16
) (
   input  logic      clock,
   input  logic      reset,
   fasq_req_if.sink  req_if,
   fasq_rsp_if.source rsp_if,
   fasq_csr_if.sink  csr_if
);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [TIMER_BITS-1:0] TIMER_ONE = TIMER_BITS'(1);
   localparam logic [TIMER_BITS-1:0] TIMER_ZERO = '0;

   // Configuration registers.
   logic [CSR_DATA_W-1:0] debounce_ff;
   logic [CSR_DATA_W-1:0] advance_pulse_ff;
   logic [CSR_DATA_W-1:0] end_pulse_ff;

   // Qualifier state.
   logic                  synced_ff,       synced_in;
   logic                  prev_advance_ff, prev_advance_in;
   logic                  prev_end_ff,     prev_end_in;
   logic                  wait_fall_ff,    wait_fall_in;
   logic [TIMER_BITS-1:0] adv_lock_ff,     adv_lock_in;
   logic                  arms_fall_ff,    arms_fall_in;
   logic [TIMER_BITS-1:0] end_lock_ff,     end_lock_in;
   logic [TIMER_BITS-1:0] adv_pulse_ff,    adv_pulse_in;
   logic [TIMER_BITS-1:0] end_pulse_ff_t,  end_pulse_in;
   logic [COUNT_BITS-1:0] count_ff,        count_in;
   logic                  led_ff,          led_in;

   // Per-tick working signals.
   logic                  adv;
   logic                  eol;
   logic                  frame_ev;
   logic                  rise_ev;
   logic                  end_ev;
   logic [TIMER_BITS+CSR_DATA_W-1:0] deb_wide;
   logic [TIMER_BITS+CSR_DATA_W-1:0] adv_len_wide;
   logic [TIMER_BITS+CSR_DATA_W-1:0] end_len_wide;
   logic [TIMER_BITS-1:0] deb;
   logic [TIMER_BITS-1:0] adv_len;
   logic [TIMER_BITS-1:0] end_len;
   logic [COUNT_BITS-1:0] report_count;
   logic [COUNT_BITS+EVENT_COUNT_W-1:0] report_wide;
   logic                  req_fire;
   logic                  buf_ready;
   rsp_payload_type       result;
   rsp_payload_type       out_data;

   assign adv      = req_if.advance_level;
   assign eol      = req_if.end_level;
   assign req_fire = req_if.valid && buf_ready;
   assign req_if.ready = buf_ready;
   assign csr_if.ready = 1'b1;

   // Register values cut or extended to the timer width.
   assign deb_wide     = {{TIMER_BITS{1'b0}}, debounce_ff};
   assign adv_len_wide = {{TIMER_BITS{1'b0}}, advance_pulse_ff};
   assign end_len_wide = {{TIMER_BITS{1'b0}}, end_pulse_ff};
   assign deb          = deb_wide[TIMER_BITS-1:0];

   always_comb begin
      adv_len = adv_len_wide[TIMER_BITS-1:0];
      end_len = end_len_wide[TIMER_BITS-1:0];
      // A zero pulse length still gives a one-tick pulse.
      if (adv_len == TIMER_ZERO) adv_len = TIMER_ONE;
      if (end_len == TIMER_ZERO) end_len = TIMER_ONE;
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff      <= DEBOUNCE_RESET;
         advance_pulse_ff <= ADVANCE_PULSE_RESET;
         end_pulse_ff     <= END_PULSE_RESET;
      end else if (csr_if.valid) begin
         unique case (csr_index_type'(csr_if.index))
            CSR_DEBOUNCE:      debounce_ff      <= csr_if.data;
            CSR_ADVANCE_PULSE: advance_pulse_ff <= csr_if.data;
            CSR_END_PULSE:     end_pulse_ff     <= csr_if.data;
            default: ;
         endcase
      end
   end

   // Edge detection, timers and events for one tick.
   always_comb begin
      synced_in       = synced_ff;
      prev_advance_in = prev_advance_ff;
      prev_end_in     = prev_end_ff;
      wait_fall_in    = wait_fall_ff;
      adv_lock_in     = adv_lock_ff;
      arms_fall_in    = arms_fall_ff;
      end_lock_in     = end_lock_ff;
      adv_pulse_in    = adv_pulse_ff;
      end_pulse_in    = end_pulse_ff_t;
      count_in        = count_ff;
      led_in          = led_ff;
      frame_ev        = 1'b0;
      rise_ev         = 1'b0;
      end_ev          = 1'b0;
      report_count    = '0;
      result.event_code = EVT_NONE;

      // The first tick only takes the pin levels and the advance phase.
      if (!synced_ff) begin
         synced_in       = 1'b1;
         prev_advance_in = adv;
         prev_end_in     = eol;
         wait_fall_in    = adv;
      end else begin
         if (adv_lock_ff == TIMER_ZERO) begin
            frame_ev = wait_fall_ff && prev_advance_ff && !adv;
            rise_ev  = !wait_fall_ff && !prev_advance_ff && adv;
         end
         end_ev          = (end_lock_ff == TIMER_ZERO) && !prev_end_ff && eol;
         prev_advance_in = adv;
         prev_end_in     = eol;
      end

      // Lockout and pulse timers count down.
      if (adv_lock_ff != TIMER_ZERO) begin
         adv_lock_in = adv_lock_ff - TIMER_ONE;
         if (adv_lock_ff == TIMER_ONE) wait_fall_in = arms_fall_ff;
      end
      if (end_lock_ff != TIMER_ZERO) begin
         end_lock_in = end_lock_ff - TIMER_ONE;
         if (end_lock_ff == TIMER_ONE) begin
            wait_fall_in = adv;
            adv_lock_in  = TIMER_ZERO;
         end
      end
      if (adv_pulse_ff != TIMER_ZERO) begin
         adv_pulse_in = adv_pulse_ff - TIMER_ONE;
         if (adv_pulse_ff == TIMER_ONE) led_in = 1'b0;
      end
      if (end_pulse_ff_t != TIMER_ZERO) begin
         end_pulse_in = end_pulse_ff_t - TIMER_ONE;
         if (end_pulse_ff_t == TIMER_ONE) led_in = 1'b0;
      end

      // An accepted advance edge starts the lockout toward the other phase.
      if (frame_ev || rise_ev) begin
         arms_fall_in = rise_ev;
         adv_lock_in  = deb;
         if (deb == TIMER_ZERO) wait_fall_in = rise_ev;
      end

      // A frame event reports and bumps the saturating count.
      if (frame_ev) begin
         result.event_code = EVT_FRAME;
         report_count      = count_ff;
         if (count_ff != COUNT_MAX) count_in = count_ff + COUNT_BITS'(1);
         adv_pulse_in      = adv_len;
         led_in            = 1'b1;
      end

      // An end event reports the count as left by a frame edge, then clears it.
      if (end_ev) begin
         result.event_code = EVT_END;
         report_count      = count_in;
         count_in          = '0;
         end_pulse_in      = end_len;
         led_in            = 1'b1;
         end_lock_in       = deb;
         if (deb == TIMER_ZERO) begin
            wait_fall_in = adv;
            adv_lock_in  = TIMER_ZERO;
         end
      end

      report_wide        = {{EVENT_COUNT_W{1'b0}}, report_count};
      result.event_count = report_wide[EVENT_COUNT_W-1:0];
      result.advance_out = (adv_pulse_in == TIMER_ZERO);
      result.end_out     = (end_pulse_in == TIMER_ZERO);
      result.led_on      = led_in;
   end

   // Control state registers, updated once per accepted request.
   always_ff @(posedge clock) begin
      if (reset) begin
         synced_ff       <= 1'b0;
         prev_advance_ff <= 1'b0;
         prev_end_ff     <= 1'b0;
         wait_fall_ff    <= 1'b0;
         adv_lock_ff     <= '0;
         arms_fall_ff    <= 1'b0;
         end_lock_ff     <= '0;
         adv_pulse_ff    <= '0;
         end_pulse_ff_t  <= '0;
         count_ff        <= '0;
         led_ff          <= 1'b0;
      end else if (req_fire) begin
         synced_ff       <= synced_in;
         prev_advance_ff <= prev_advance_in;
         prev_end_ff     <= prev_end_in;
         wait_fall_ff    <= wait_fall_in;
         adv_lock_ff     <= adv_lock_in;
         arms_fall_ff    <= arms_fall_in;
         end_lock_ff     <= end_lock_in;
         adv_pulse_ff    <= adv_pulse_in;
         end_pulse_ff_t  <= end_pulse_in;
         count_ff        <= count_in;
         led_ff          <= led_in;
      end
   end

   // Result buffer toward the result channel.
   fasq_out_buffer u_out_buffer (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_if.valid),
      .in_ready  (buf_ready),
      .in_data   (result),
      .out_valid (rsp_if.valid),
      .out_ready (rsp_if.ready),
      .out_data  (out_data)
   );

   assign rsp_if.advance_out = out_data.advance_out;
   assign rsp_if.end_out     = out_data.end_out;
   assign rsp_if.led_on      = out_data.led_on;
   assign rsp_if.event_code  = out_data.event_code;
   assign rsp_if.event_count = out_data.event_count;

   // A reported frame event always shows its pulse active.
   a_frame_pulse: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.event_code == EVT_FRAME) |-> (!rsp_if.advance_out && rsp_if.led_on))
      else $error("frame event without active advance pulse");

   // A reported end event always shows its pulse and the LED.
   a_end_pulse: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.event_code == EVT_END) |-> (!rsp_if.end_out && rsp_if.led_on))
      else $error("end event without active end pulse");

   // No event means no count is reported.
   a_idle_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.event_code == EVT_NONE) |-> (rsp_if.event_count == '0))
      else $error("count reported without an event");

   // The first accepted request always synchronizes the qualifier.
   a_sync: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> synced_ff)
      else $error("qualifier not synchronized after a request");

endmodule
